// ===== src/mavg_pkg.sv =====
// shared constants and types for the boxcar moving average filter
`default_nettype none
package mavg_pkg;

  localparam int MAX_TAPS_DEF   = 256;
  localparam int SAMPLE_W       = 16;
  localparam int FILTER_LEN_W   = 8;
  localparam logic [FILTER_LEN_W-1:0] FILTER_LEN_RST = 8'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MODW,
    ST_RD,
    ST_UPD,
    ST_SWEEP,
    ST_DIV,
    ST_DIVW,
    ST_OUT
  } mavg_state_t;

endpackage
`default_nettype wire

// ===== src/mavg_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mavg_div.sv =====
// restoring divider, one quotient bit per cycle, 16-bit quotient
`default_nettype none
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SUM_W = 24,
  parameter int LEN_W = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SUM_W-1:0]    dividend,
  input  wire logic [LEN_W-1:0]    divisor,
  output logic                     done,
  output logic [SAMPLE_W-1:0]      quotient,
  output logic [LEN_W-1:0]         remainder
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] quo_r, quo_nxt;
  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;

  assign trial = {rem_r, quo_r[SAMPLE_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      // upper part is already below the divisor, so the quotient fits 16 bits
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = LEN_W'(dividend[SUM_W-1:SAMPLE_W]);
      quo_nxt  = dividend[SAMPLE_W-1:0];
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[LEN_W-1:0];
        quo_nxt = {quo_r[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LEN_W-1:0];
        quo_nxt = {quo_r[SAMPLE_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== src/moving_average_filter_top.sv =====
// boxcar moving average filter: ring store in ram, running sum, serial divider
// per sample: read, update, 16-step divide, output; a modulo divide comes first
// when the write position wraps from beyond a shortened window, and a sweep of the
// window follows the update on the first sample after a filter_len write (sum rebuild)
// throughput: one sample at a time; the next is taken once the result is registered
// reset: synchronous active low; store reads as zero through per-entry valid bits,
// position and sum go to zero, filter_len goes to 8
`default_nettype none
module moving_average_filter_top
  import mavg_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_W-1:0]     in_sample,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SAMPLE_W-1:0]          out_average,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [FILTER_LEN_W-1:0] cfg_filter_len
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int SUM_W = SAMPLE_W + AW;

  mavg_state_t state_r, state_nxt;

  logic [FILTER_LEN_W-1:0] filter_len_r, filter_len_nxt;
  logic                    dirty_r, dirty_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           npos_r, npos_nxt;
  logic [SAMPLE_W-1:0]     sample_r, sample_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic                    acc_v_r, acc_v_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]     out_average_r, out_average_nxt;
  logic [MAX_TAPS-1:0]     vld_r, vld_nxt;
  logic                    rd_vld_r;

  logic [FILTER_LEN_W:0]   fl_ext;
  logic [LEN_W-1:0]        len_w;
  logic [LEN_W-1:0]        pos_inc;
  logic                    in_acc;
  logic                    cfg_acc;

  logic                    ram_we;
  logic [AW-1:0]           rd_addr;
  logic [SAMPLE_W-1:0]     ram_rdata;
  logic [SAMPLE_W-1:0]     old_val;

  logic                    div_start;
  logic [SUM_W-1:0]        div_dividend;
  logic                    div_done;
  logic [SAMPLE_W-1:0]     div_quo;
  logic [LEN_W-1:0]        div_rem;

  // effective window length: zero means one, clamp to the store depth
  always_comb begin
    fl_ext = {1'b0, filter_len_r};
    if (filter_len_r == '0) begin
      len_w = LEN_W'(1);
    end else if (fl_ext > (FILTER_LEN_W + 1)'(MAX_TAPS)) begin
      len_w = LEN_W'(MAX_TAPS);
    end else begin
      len_w = LEN_W'(fl_ext);
    end
  end

  assign pos_inc   = LEN_W'(pos_r) + 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign old_val   = rd_vld_r ? ram_rdata : '0;

  always_comb begin
    state_nxt       = state_r;
    filter_len_nxt  = cfg_acc ? cfg_filter_len : filter_len_r;
    dirty_nxt       = dirty_r;
    pos_nxt         = pos_r;
    npos_nxt        = npos_r;
    sample_nxt      = sample_r;
    sum_nxt         = sum_r;
    cnt_nxt         = cnt_r;
    acc_v_nxt       = acc_v_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_average_nxt = out_average_r;
    vld_nxt         = vld_r;
    ram_we          = 1'b0;
    rd_addr         = npos_r;
    div_start       = 1'b0;
    div_dividend    = sum_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_sample;
          if (pos_inc < len_w) begin
            npos_nxt  = AW'(pos_inc);
            state_nxt = ST_RD;
          end else if (pos_inc == len_w) begin
            npos_nxt  = '0;
            state_nxt = ST_RD;
          end else begin
            // position left beyond a shortened window: take the true modulo
            div_start    = 1'b1;
            div_dividend = SUM_W'(pos_inc);
            state_nxt    = ST_MODW;
          end
        end
      end
      ST_MODW: begin
        if (div_done) begin
          npos_nxt  = AW'(div_rem);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we           = 1'b1;
        vld_nxt[npos_r]  = 1'b1;
        pos_nxt          = npos_r;
        if (dirty_r) begin
          // window length changed: rebuild the sum from the store
          dirty_nxt = 1'b0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          acc_v_nxt = 1'b0;
          state_nxt = ST_SWEEP;
        end else begin
          sum_nxt   = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
          state_nxt = ST_DIV;
        end
      end
      ST_SWEEP: begin
        if (acc_v_r) begin
          sum_nxt = sum_r + SUM_W'(old_val);
        end
        if (cnt_r != len_w) begin
          rd_addr   = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          acc_v_nxt = 1'b1;
        end else begin
          acc_v_nxt = 1'b0;
          if (!acc_v_r) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = div_quo;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      filter_len_r <= FILTER_LEN_RST;
      dirty_r      <= 1'b0;
      pos_r        <= '0;
      sum_r        <= '0;
      acc_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      vld_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      filter_len_r <= filter_len_nxt;
      dirty_r      <= dirty_nxt;
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      acc_v_r      <= acc_v_nxt;
      out_valid_r  <= out_valid_nxt;
      vld_r        <= vld_nxt;
    end
    npos_r        <= npos_nxt;
    sample_r      <= sample_nxt;
    cnt_r         <= cnt_nxt;
    out_average_r <= out_average_nxt;
    rd_vld_r      <= vld_r[rd_addr];
  end

  mavg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (npos_r),
    .wdata (sample_r),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  mavg_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (len_w),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule
`default_nettype wire

// ===== src/mavg_checker.sv =====
// port-level checks for the moving average filter, bound to the top level
`default_nettype none
module mavg_checker
  import mavg_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_average
);

  // requests taken but not yet delivered
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second request taken while one is in work");

  a_out_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result without a pending request");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

endmodule

bind moving_average_filter_top mavg_checker u_mavg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_average (out_average)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the boxcar moving average filter
`timescale 1ns / 100ps
module testbench;
  import mavg_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 300;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SAMPLE_W-1:0]     out_average;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [FILTER_LEN_W-1:0] cfg_filter_len = '0;

  // local copy of the filter state
  logic [SAMPLE_W-1:0]     ring_mem [MAX_TAPS_DEF] = '{default: '0};
  logic [7:0]              ring_pos = '0;
  logic [FILTER_LEN_W-1:0] window_len = FILTER_LEN_RST;

  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [SAMPLE_W-1:0] expected_averages[$];
  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  moving_average_filter_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_filter_len(cfg_filter_len)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // advance the ring and return the truncated window mean
  function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] smp);
    int unsigned wlen;
    int unsigned sum;
    int unsigned mean;
    wlen = (window_len == 0) ? 1 : int'(window_len);
    ring_pos = 8'((int'(ring_pos) + 1) % wlen);
    ring_mem[ring_pos] = smp;
    sum = 0;
    for (int k = 0; k < wlen; k++) sum += ring_mem[k];
    mean = sum / wlen;
    if (mean > 32'hFFFF) mean = 32'hFFFF;
    return mean[SAMPLE_W-1:0];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 10);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(input bit high_bias);
    int unsigned r;
    if (high_bias && $urandom_range(0, 3) != 0) return '1;
    r = $urandom_range(0, 19);
    case (r)
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(0, 15));
      3: return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
    pending_samples.push_back(smp);
    pushed_cnt++;
  endtask

  // always waits on the clock before the first check so cfg_valid never gets two updates in a step
  task automatic wait_idle();
    do @(posedge clk);
    while (!(accepted_cnt == pushed_cnt && expected_averages.size() == 0));
  endtask

  task automatic write_filter_len(input logic [FILTER_LEN_W-1:0] len);
    cfg_filter_len <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_len = len;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_averages.push_back(next_average(in_sample));
        accepted_cnt++;
        gap_left = (sender_steady || $urandom_range(0, 2) != 0) ? 0 : idle_gap();
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid <= 1'b1;
          in_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected result: average actual %0d", out_average);
          errors++;
        end else begin
          want = expected_averages.pop_front();
          if (out_average !== want) begin
            $error("average mismatch: expected %0d, actual %0d", want, out_average);
            errors++;
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!receiver_steady && $urandom_range(0, 7) == 0) stall_left = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // -1 picks a random window length
    int plan_len[13] = '{1, 255, 2, 254, 128, 0, -1, 3, -1, 255, 16, -1, 7};
    int plan_cnt[13] = '{80, 300, 80, 280, 150, 40, 100, 80, 100, 100, 100, 100, 90};
    logic [FILTER_LEN_W-1:0] len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset length, ramp-up through unwritten entries
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'hAAAA);
    push_sample(16'h5555);
    repeat (4) push_sample(16'hFFFF);
    wait_idle();
    // widest window with large values
    write_filter_len(8'd255);
    repeat (6) push_sample(16'hFFFF);
    wait_idle();
    // shrink below the current position, ring wraps back in range
    write_filter_len(8'd4);
    push_sample(16'h1234);
    push_sample(16'hFFFE);
    push_sample(16'h0002);
    wait_idle();
    // zero length behaves as one
    write_filter_len(8'd0);
    push_sample(16'hFFFF);
    push_sample(16'h0003);
    wait_idle();
    write_filter_len(8'd1);
    push_sample(16'h0000);
    push_sample(16'hC3A5);
    wait_idle();

    for (int p = 0; p < 13; p++) begin
      len = (plan_len[p] < 0) ? FILTER_LEN_W'($urandom_range(1, 255)) : plan_len[p][7:0];
      write_filter_len(len);
      sender_steady = (p == 4 || p == 10 || p == 1 || p == 6);
      receiver_steady = (p == 4 || p == 10);
      // stall the output while the sender keeps requests coming
      if (p == 1 || p == 6) hold_requests++;
      for (int i = 0; i < plan_cnt[p]; i++) push_sample(random_sample(len >= 8'd254));
      wait_idle();
    end

    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
